// File: src/differential_drive_odometry_top_defines.svh
// Assertion macros for the odometry block.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define DDO_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define DDO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

// File: src/ddo_pkg.sv
// Shared types, constants and tables for the odometry block.
package ddo_pkg;

    localparam int CordicStepsDefault = 24;
    localparam logic [15:0] TrackWidthReset = 16'd7168;
    localparam logic [15:0] TrackWidthMin   = 16'd256;
    localparam logic [31:0] KTurn = 32'd79027398;
    localparam logic [31:0] KStep = 32'd100364796;
    localparam logic signed [31:0] TwoPiQ24 = 32'sd105414357;
    localparam logic signed [31:0] PiQ24    = 32'sd52707179;
    localparam logic signed [33:0] PiQ30    = 34'sd3373259426;
    localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic signed [39:0] Max40 = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] Min40 = 40'sh80_0000_0000;
    localparam logic [0:0] RegTrackWidth = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TURN_MUL,
        ST_TURN_DIV,
        ST_STEP_MUL,
        ST_UPDATE,
        ST_MOD,
        ST_CORDIC,
        ST_XY_MUL,
        ST_ACCUM,
        ST_OUT
    } ddo_state_t;

    // Truncated atan(2^-i) in Q2.30.
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'h3243F6A8;
                5'd1:  v = 32'h1DAC6705;
                5'd2:  v = 32'h0FAADD4B;
                5'd3:  v = 32'h07F56EA6;
                5'd4:  v = 32'h03FEAB76;
                5'd5:  v = 32'h01FFD55B;
                5'd6:  v = 32'h00FFFAAA;
                5'd7:  v = 32'h007FFF55;
                5'd8:  v = 32'h003FFFEA;
                5'd9:  v = 32'h001FFFFD;
                5'd10: v = 32'h000FFFFF;
                5'd11: v = 32'h0007FFFF;
                5'd12: v = 32'h0003FFFF;
                5'd13: v = 32'h0001FFFF;
                5'd14: v = 32'h0000FFFF;
                5'd15: v = 32'h00007FFF;
                5'd16: v = 32'h00003FFF;
                5'd17: v = 32'h00001FFF;
                5'd18: v = 32'h00000FFF;
                5'd19: v = 32'h000007FF;
                5'd20: v = 32'h000003FF;
                5'd21: v = 32'h000001FF;
                5'd22: v = 32'h000000FF;
                5'd23: v = 32'h0000007F;
                5'd24: v = 32'h0000003F;
                5'd25: v = 32'h0000001F;
                5'd26: v = 32'h0000000F;
                5'd27: v = 32'h00000008;
                5'd28: v = 32'h00000004;
                5'd29: v = 32'h00000002;
                5'd30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            return {2'b00, v};
        end
    endfunction

    // Saturate a 48-bit sum to 40 bits signed.
    function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
        begin
            if (v > 48'(Max40))
                return Max40;
            else if (v < 48'(Min40))
                return Min40;
            return v[39:0];
        end
    endfunction

endpackage

// File: src/ddo_if.sv
// Valid/ready channel interfaces for the odometry block.
interface ddo_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_count;
    logic [31:0] right_count;
    logic        clear_distance;
    modport source (output valid, left_count, right_count, clear_distance, input ready);
    modport sink   (input valid, left_count, right_count, clear_distance, output ready);
endinterface

interface ddo_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] heading;
    logic [39:0] path_distance;
    logic [39:0] pos_x;
    logic [39:0] pos_y;
    logic [31:0] speed;
    modport source (output valid, heading, path_distance, pos_x, pos_y, speed, input ready);
    modport sink   (input valid, heading, path_distance, pos_x, pos_y, speed, output ready);
endinterface

// File: src/differential_drive_odometry_top.sv
// Differential-drive odometry: top level with sequencer, divider and CORDIC.
//
// Usage:
//   in_ch  (sink): one transaction per encoder tick with left_count,
//          right_count and clear_distance.
//   out_ch (source): one transaction per tick with heading, path_distance,
//          pos_x, pos_y and speed.
//   APB port: register 0 at byte address 0 holds track_width (Q8.8 inches),
//          reset 7168. Writes take effect on the next accepted tick.
// Sequence: a radix-4 multiply and a restoring divide for the turn, a
//   multiply for the step, a modulo reduction of the heading, one CORDIC
//   iteration per cycle and two multiplies for the x and y increments;
//   out_ch.valid is set after the ACCUM and OUT states.
// Flow: one tick in flight at a time; in_ch.ready returns the cycle after
//   the result is taken.
// Reset: all accumulators and previous counts clear; track_width reloads.
// Stall: a result is held in the output register until taken; a new tick is
//   accepted once the result register is free.
`include "differential_drive_odometry_top_defines.svh"
module differential_drive_odometry_top #(
    parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    ddo_in_if.sink      in_ch,
    ddo_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ddo_pkg::*;

    localparam int CntW = $clog2(CORDIC_STEPS + 1);

    ddo_state_t state_reg, state_next;

    logic [15:0] track_width_reg;
    logic [31:0] prev_left_reg, prev_right_reg;
    logic signed [31:0] heading_reg;
    logic signed [39:0] dist_reg, x_reg, y_reg;
    logic signed [31:0] speed_reg;
    logic out_valid_reg;

    // Work registers
    logic signed [32:0] dsum_reg, ddiff_reg;   // tr+tl, tr-tl
    logic signed [44:0] step_reg;
    logic [16:0] rem_reg;                       // restoring divide remainder
    logic [59:0] num_reg;                       // dividend in, quotient out
    logic [16:0] tw_reg;
    logic [6:0]  div_cnt_reg;
    logic signed [31:0] r_reg;                  // modulo remainder
    logic signed [39:0] mod_sub_reg;
    logic [5:0]  mod_cnt_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic [CntW-1:0] ci_reg;
    logic flip_reg;
    logic sel_y_reg;
    logic signed [45:0] incx_reg;

    // APB
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[1:1] == RegTrackWidth) ? {16'd0, track_width_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            track_width_reg <= TrackWidthReset;
        else if (cfg_wr && paddr[1:1] == RegTrackWidth)
            track_width_reg <= pwdata[15:0];
    end

    // Shared serial multiplier
    logic        mul_start, mul_done;
    logic [47:0] mul_a;
    logic [31:0] mul_b;
    logic [79:0] mul_p;

    ddo_serial_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .product(mul_p)
    );

    // Input decode
    logic in_acc;
    logic [31:0] negr, tl32, tr32;
    logic signed [32:0] tl, tr;
    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_acc = in_ch.valid && in_ch.ready;
    assign negr = 32'd0 - in_ch.right_count;
    assign tl32 = in_ch.left_count - prev_left_reg;
    assign tr32 = negr - prev_right_reg;
    assign tl = {tl32[31], tl32};
    assign tr = {tr32[31], tr32};

    // Divider step
    logic [17:0] div_trial;
    assign div_trial = {rem_reg, num_reg[59]} - {1'b0, tw_reg};

    // Modulo step
    logic signed [31:0] r_mod;
    assign r_mod = (r_reg >= 0 && 40'(r_reg) >= mod_sub_reg) ? 32'(40'(r_reg) - mod_sub_reg)
                 : ((r_reg < 0 && -40'(r_reg) >= mod_sub_reg) ? 32'(40'(r_reg) + mod_sub_reg)
                 : r_reg);

    // CORDIC step
    logic signed [33:0] sh_x, sh_y;
    assign sh_x = cx_reg >>> ci_reg;
    assign sh_y = cy_reg >>> ci_reg;

    // Rounded products
    logic [63:0] step_mag;
    logic [49:0] xy_mag;
    assign step_mag = (mul_p[63:0] + 64'd32768) >> 16;
    assign xy_mag = 50'((mul_p + 80'd536870912) >> 30);

    // Cosine magnitude for the y product
    logic signed [33:0] sel_trig;
    logic [31:0] trig_mag;
    logic [44:0] step_abs;
    assign sel_trig = cx_reg;
    assign trig_mag = sel_trig[33] ? 32'(-sel_trig) : sel_trig[31:0];
    assign step_abs = step_reg[44] ? 45'(-step_reg) : step_reg;

    logic signed [32:0] hsum;
    logic signed [31:0] hnew;
    logic signed [51:0] spd_full;
    logic signed [33:0] z0;
    assign spd_full = step_reg * 52'sd50;
    assign z0 = {r_reg[31], r_reg[31], r_reg} <<< 6;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_acc) state_next = ST_TURN_MUL;
            ST_TURN_MUL: if (mul_done) state_next = ST_TURN_DIV;
            ST_TURN_DIV: if (div_cnt_reg == 7'd60) state_next = ST_STEP_MUL;
            ST_STEP_MUL: if (mul_done) state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_MOD;
            ST_MOD:      if (mod_cnt_reg == 6'd0) state_next = ST_CORDIC;
            ST_CORDIC:   if (ci_reg == CntW'(CORDIC_STEPS)) state_next = ST_XY_MUL;
            ST_XY_MUL:   if (mul_done && sel_y_reg) state_next = ST_ACCUM;
            ST_ACCUM:    state_next = ST_OUT;
            ST_OUT:      state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Multiplier launch
    always_comb
    begin
        mul_start = 1'b0;
        mul_a = 48'd0;
        mul_b = 32'd0;
        case (state_reg)
            ST_IDLE:
            begin
                mul_start = in_acc;
                mul_a = (tr - tl < 0) ? -48'(tr - tl) : 48'(tr - tl);
                mul_b = KTurn;
            end
            ST_TURN_DIV:
            begin
                mul_start = (div_cnt_reg == 7'd60);
                mul_a = (dsum_reg < 0) ? -48'(dsum_reg) : 48'(dsum_reg);
                mul_b = KStep;
            end
            ST_CORDIC:
            begin
                mul_start = (ci_reg == CntW'(CORDIC_STEPS));
                mul_a = {3'd0, step_abs};
                mul_b = (cy_reg[33] ? 32'(-cy_reg) : cy_reg[31:0]);
            end
            ST_XY_MUL:
            begin
                mul_start = mul_done && !sel_y_reg;
                mul_a = {3'd0, step_abs};
                mul_b = trig_mag;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    dsum_reg <= tr + tl;
                    ddiff_reg <= tr - tl;
                    tw_reg <= {1'b0, (track_width_reg < TrackWidthMin) ? TrackWidthMin
                                                                       : track_width_reg};
                end
            end
            ST_TURN_MUL:
            begin
                num_reg <= mul_p[59:0];
                rem_reg <= '0;
                div_cnt_reg <= 7'd0;
            end
            ST_TURN_DIV:
            begin
                if (div_cnt_reg != 7'd60)
                begin
                    div_cnt_reg <= div_cnt_reg + 7'd1;
                    if (!div_trial[17])
                    begin
                        rem_reg <= div_trial[16:0];
                        num_reg <= {num_reg[58:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[15:0], num_reg[59]};
                        num_reg <= {num_reg[58:0], 1'b0};
                    end
                end
            end
            ST_STEP_MUL:
            begin
                if (mul_done)
                    step_reg <= dsum_reg < 0 ? -45'(step_mag) : 45'(step_mag);
            end
            ST_UPDATE:
            begin
                r_reg <= hnew;
                mod_sub_reg <= 40'(TwoPiQ24) <<< 5;
                mod_cnt_reg <= 6'd5;
            end
            ST_MOD:
            begin
                // Truncating remainder: subtract 2pi*2^k when magnitude allows.
                r_reg <= r_mod;
                mod_sub_reg <= mod_sub_reg >>> 1;
                if (mod_cnt_reg != 6'd0)
                    mod_cnt_reg <= mod_cnt_reg - 6'd1;
                else
                begin
                    cx_reg <= CordicGain;
                    cy_reg <= 34'sd0;
                    ci_reg <= '0;
                    begin
                        logic signed [31:0] rr;
                        logic signed [33:0] zz;
                        rr = r_mod;
                        if (rr < 0) rr = rr + TwoPiQ24;
                        if (rr > PiQ24) rr = rr - TwoPiQ24;
                        zz = 34'(rr) <<< 6;
                        if (zz > HalfPiQ30)
                        begin
                            cz_reg <= zz - PiQ30;
                            flip_reg <= 1'b1;
                        end
                        else if (zz < -HalfPiQ30)
                        begin
                            cz_reg <= zz + PiQ30;
                            flip_reg <= 1'b1;
                        end
                        else
                        begin
                            cz_reg <= zz;
                            flip_reg <= 1'b0;
                        end
                    end
                end
            end
            ST_CORDIC:
            begin
                if (ci_reg != CntW'(CORDIC_STEPS))
                begin
                    ci_reg <= ci_reg + CntW'(1);
                    if (cz_reg >= 0)
                    begin
                        cx_reg <= cx_reg - sh_y;
                        cy_reg <= cy_reg + sh_x;
                        cz_reg <= cz_reg - atan_q30(5'(ci_reg));
                    end
                    else
                    begin
                        cx_reg <= cx_reg + sh_y;
                        cy_reg <= cy_reg - sh_x;
                        cz_reg <= cz_reg + atan_q30(5'(ci_reg));
                    end
                end
                else
                begin
                    if (flip_reg)
                    begin
                        cx_reg <= -cx_reg;
                        cy_reg <= -cy_reg;
                    end
                    sel_y_reg <= 1'b0;
                end
            end
            ST_XY_MUL:
            begin
                if (mul_done && !sel_y_reg)
                begin
                    incx_reg <= (step_reg[44] ^ cy_reg[33]) ? -46'(xy_mag) : 46'(xy_mag);
                    sel_y_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Architectural state
    logic signed [45:0] incy;
    assign incy = (step_reg[44] ^ cx_reg[33]) ? -46'(xy_mag) : 46'(xy_mag);

    // Heading increment with the quotient saturated past 32 bits
    always_comb
    begin
        logic [32:0] q_mag;
        logic signed [47:0] q;
        q_mag = (num_reg[59:32] != 28'd0) ? 33'h1_0000_0000 : {1'b0, num_reg[31:0]};
        q = ddiff_reg < 0 ? -48'(q_mag) : 48'(q_mag);
        hsum = 33'(48'(heading_reg) + q > 48'sh7FFFFFFF ? 48'sh7FFFFFFF
               : (48'(heading_reg) + q < -48'sh80000000 ? -48'sh80000000
               : 48'(heading_reg) + q));
        hnew = hsum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            prev_left_reg <= '0;
            prev_right_reg <= '0;
            heading_reg <= '0;
            dist_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            speed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (in_acc)
            begin
                prev_left_reg <= in_ch.left_count;
                prev_right_reg <= negr;
                if (in_ch.clear_distance)
                    dist_reg <= '0;
            end
            if (state_reg == ST_UPDATE)
            begin
                heading_reg <= hnew;
                dist_reg <= sat40(48'(dist_reg) + 48'(step_reg));
                speed_reg <= spd_full > 52'sh7FFFFFFF ? 32'sh7FFFFFFF
                           : (spd_full < -52'sh80000000 ? 32'sh80000000 : spd_full[31:0]);
            end
            if (state_reg == ST_XY_MUL && mul_done && sel_y_reg)
            begin
                x_reg <= sat40(48'(x_reg) + 48'(incx_reg));
                y_reg <= sat40(48'(y_reg) + 48'(incy));
            end
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.heading = heading_reg;
    assign out_ch.path_distance = dist_reg;
    assign out_ch.pos_x = x_reg;
    assign out_ch.pos_y = y_reg;
    assign out_ch.speed = speed_reg;

    `DDO_ASSERT_IMP(a_no_accept_busy, state_reg != ST_IDLE, !in_ch.ready)
    `DDO_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ch.ready, out_valid_reg)
    `DDO_ASSERT_NEXT(a_out_after_seq, state_reg == ST_OUT, out_valid_reg)
endmodule

// File: src/ddo_serial_mul.sv
// Radix-4 shift-add multiplier: unsigned 48 x 32, two multiplier bits per cycle.
module ddo_serial_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [79:0] product
);
    logic [79:0] acc_reg, acc_next;
    logic [79:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [79:0] part;

    // Digit partial product and step control
    always_comb
    begin
        part = (mplier_reg[0] ? mcand_reg : 80'd0)
             + (mplier_reg[1] ? {mcand_reg[78:0], 1'b0} : 80'd0);
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = 80'd0;
            mcand_next = {32'd0, a};
            mplier_next = b;
            cnt_next = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + part;
            mcand_next = {mcand_reg[77:0], 2'b00};
            mplier_next = {2'b00, mplier_reg[31:2]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign product = acc_reg;
endmodule
